// ----- hw/rtl/spc_pkg.sv -----
// shared constants and types for the stereo phase correlation block
`timescale 1ns / 1ps
package spc_pkg;

  // default accumulator width
  localparam int ACC_WIDTH_DEF = 48;
  // entries in the queue between the front and back ends
  localparam int QUEUE_DEPTH = 2;
  // fraction bits of the result
  localparam int FRAC_BITS = 15;
  // register index of sample_stride
  localparam logic REG_SAMPLE_STRIDE = 1'b0;
  // reset value of sample_stride
  localparam logic [7:0] STRIDE_RESET = 8'd1;
  // result limits
  localparam logic [15:0] CORR_POS_MAX = 16'h7fff;
  localparam logic [15:0] CORR_NEG_MAX = 16'h8000;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } back_state_t;

  // queue status seen by the front end
  typedef struct packed {
    logic [1:0] count;
    logic       push;
  } queue_ctl_t;

endpackage

// ----- hw/rtl/spc_fifo.sv -----
// short queue of finished block sums between front and back ends
`timescale 1ns / 1ps
module spc_fifo #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(DEPTH)) |-> (!push || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ----- hw/rtl/spc_front.sv -----
// front end: stride selection, products and saturating block sums
`timescale 1ns / 1ps
module spc_front #(
  parameter int ACC_WIDTH = spc_pkg::ACC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     left_sample,
  input  logic signed [15:0]     right_sample,
  input  logic                   last_sample,
  input  logic [7:0]             sample_stride,
  input  spc_pkg::queue_ctl_t    q_stat,
  output logic                   push,
  output logic [3*ACC_WIDTH-1:0] push_data
);
  import spc_pkg::*;

  localparam int AW = ACC_WIDTH;

  logic                 accept;
  logic [7:0]           stride;
  logic [7:0]           phase_r, phase_nxt, phase_inc;
  logic                 s1_valid_r, s1_acc_r, s1_last_r;
  logic signed [31:0]   px_r, pl_r, pr_r;
  logic signed [AW-1:0] cross_r, left_r, right_r;
  logic signed [AW-1:0] cross_nxt, left_nxt, right_nxt;
  logic signed [AW-1:0] cross_sum, left_sum, right_sum;

  // saturating add of a product to a sum
  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                   input logic signed [31:0] p);
    logic signed [AW:0] wide;
    wide = {a[AW-1], a} + {{(AW+1-32){p[31]}}, p};
    if (wide[AW] != wide[AW-1]) begin
      sat_add = wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sat_add = wide[AW-1:0];
    end
  endfunction

  // room for one more block result, counting one still in the pipe
  assign in_ready = ({1'b0, q_stat.count} + {2'b0, s1_valid_r & s1_last_r})
                    < 3'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign stride   = (sample_stride == '0) ? 8'd1 : sample_stride;

  // phase within the stride
  always_comb begin
    phase_inc = phase_r + 8'd1;
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = (phase_inc >= stride || last_sample) ? 8'd0 : phase_inc;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_acc_r  <= (phase_r == 8'd0);
      s1_last_r <= last_sample;
      px_r      <= left_sample * right_sample;
      pl_r      <= left_sample * left_sample;
      pr_r      <= right_sample * right_sample;
    end
  end

  // stage 2: accumulate, hand off and clear at block end
  always_comb begin
    cross_sum = cross_r;
    left_sum  = left_r;
    right_sum = right_r;
    if (s1_acc_r) begin
      cross_sum = sat_add(cross_r, px_r);
      left_sum  = sat_add(left_r, pl_r);
      right_sum = sat_add(right_r, pr_r);
    end
    cross_nxt = cross_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (s1_valid_r) begin
      cross_nxt = s1_last_r ? '0 : cross_sum;
      left_nxt  = s1_last_r ? '0 : left_sum;
      right_nxt = s1_last_r ? '0 : right_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_r <= '0;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      cross_r <= cross_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign push      = s1_valid_r && s1_last_r;
  assign push_data = {cross_sum, left_sum, right_sum};

  // checks
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < stride || phase_r == 8'd0 || $past(sample_stride) != sample_stride)
    else $error("stride phase out of range");
  a_phase_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_sample) |=> (phase_r == 8'd0))
    else $error("phase not restarted after block end");
  a_energy_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !left_r[AW-1] && !right_r[AW-1])
    else $error("energy sum negative");

endmodule

// ----- hw/rtl/spc_back.sv -----
// back end: square roots, product of roots and quotient per block
`timescale 1ns / 1ps
module spc_back #(
  parameter int ACC_WIDTH = spc_pkg::ACC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  logic [3*ACC_WIDTH-1:0] q_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     correlation,
  output logic                   silent
);
  import spc_pkg::*;

  localparam int AW = ACC_WIDTH;
  localparam int SW = (AW + 1) / 2;
  localparam int VW = 2 * SW;
  localparam int CW = $clog2(((SW > FRAC_BITS) ? SW : FRAC_BITS) + 1);

  back_state_t   state_r, state_nxt;
  logic [AW-1:0] cross_in, left_in, right_in;
  logic [VW-1:0] vl_r, vl_nxt, vr_r, vr_nxt;
  logic [VW-1:0] rl_r, rl_nxt, rr_r, rr_nxt;
  logic [VW-1:0] bit_r, bit_nxt;
  logic [VW-1:0] tl, tr;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic          silent_r, silent_nxt;
  logic          sat_r, sat_nxt;
  logic [VW-1:0] d_r, d_nxt;
  logic [VW:0]   rem_r, rem_nxt, rem_sh;
  logic [14:0]   q_r, q_nxt;
  logic [15:0]   corr_val;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   corr_r, corr_nxt;
  logic          out_silent_r, out_silent_nxt;

  assign {cross_in, left_in, right_in} = q_data;
  assign tl     = rl_r + bit_r;
  assign tr     = rr_r + bit_r;
  assign rem_sh = {rem_r[VW-1:0], 1'b0};

  // signed result from magnitude and sign
  always_comb begin
    if (silent_r) begin
      corr_val = '0;
    end else if (sat_r) begin
      corr_val = neg_r ? CORR_NEG_MAX : CORR_POS_MAX;
    end else begin
      corr_val = neg_r ? (16'd0 - {1'b0, q_r}) : {1'b0, q_r};
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    vl_nxt         = vl_r;
    vr_nxt         = vr_r;
    rl_nxt         = rl_r;
    rr_nxt         = rr_r;
    bit_nxt        = bit_r;
    cnt_nxt        = cnt_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    silent_nxt     = silent_r;
    sat_nxt        = sat_r;
    d_nxt          = d_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    pop            = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    corr_nxt       = corr_r;
    out_silent_nxt = out_silent_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          vl_nxt     = VW'(left_in);
          vr_nxt     = VW'(right_in);
          rl_nxt     = '0;
          rr_nxt     = '0;
          bit_nxt    = VW'(1) << (VW - 2);
          cnt_nxt    = CW'(SW);
          neg_nxt    = cross_in[AW-1];
          mag_nxt    = cross_in[AW-1] ? (AW'(0) - cross_in) : cross_in;
          sat_nxt    = 1'b0;
          q_nxt      = '0;
          silent_nxt = left_in[AW-1] || left_in == '0 ||
                       right_in[AW-1] || right_in == '0;
          state_nxt  = silent_nxt ? ST_DONE : ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one digit pair of both roots per cycle
        if (vl_r >= tl) begin
          vl_nxt = vl_r - tl;
          rl_nxt = (rl_r >> 1) + bit_r;
        end else begin
          rl_nxt = rl_r >> 1;
        end
        if (vr_r >= tr) begin
          vr_nxt = vr_r - tr;
          rr_nxt = (rr_r >> 1) + bit_r;
        end else begin
          rr_nxt = rr_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        d_nxt     = VW'(rl_r[SW-1:0]) * VW'(rr_r[SW-1:0]);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        rem_nxt = (VW+1)'(mag_r);
        cnt_nxt = CW'(FRAC_BITS);
        if ((VW+1)'(mag_r) >= {1'b0, d_r}) begin
          sat_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= {1'b0, d_r}) begin
          rem_nxt = rem_sh - {1'b0, d_r};
          q_nxt   = {q_r[13:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = {q_r[13:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          corr_nxt       = corr_val;
          out_silent_nxt = silent_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    vl_r         <= vl_nxt;
    vr_r         <= vr_nxt;
    rl_r         <= rl_nxt;
    rr_r         <= rr_nxt;
    bit_r        <= bit_nxt;
    cnt_r        <= cnt_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    silent_r     <= silent_nxt;
    sat_r        <= sat_nxt;
    d_r          <= d_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    corr_r       <= corr_nxt;
    out_silent_r <= out_silent_nxt;
  end

  assign out_valid   = out_valid_r;
  assign correlation = corr_r;
  assign silent      = out_silent_r;

  // checks
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_silent_r) |-> (corr_r == '0))
    else $error("silent result with nonzero correlation");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == ST_IDLE && q_valid))
    else $error("queue pop outside idle");
  a_div_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {1'b0, d_r}))
    else $error("division remainder not below divisor");

endmodule

// ----- hw/rtl/stereo_phase_correlation_top.sv -----
// top level: register port, front end, queue and back end
// out_valid rises once the back end finishes a block; a silent block skips the roots and divide
// throughput: one sample pair per cycle within a block while in_ready is high, set by the
// two-stage product and sum pipe; per block the back end is busy with roots and divide
// a two-entry queue holds block sums; short blocks stall the input once it fills
// synchronous active-low reset clears sums, phase, queue and sets sample_stride to 1
`timescale 1ns / 1ps
module stereo_phase_correlation_top #(
  parameter int ACC_WIDTH = spc_pkg::ACC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_left_sample,
  input  logic signed [15:0] in_right_sample,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_correlation,
  output logic               out_silent,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import spc_pkg::*;

  localparam int QW = 3 * ACC_WIDTH;

  logic [7:0]  stride_r, stride_nxt;
  logic        cfg_wr;
  logic        push, pop, q_valid;
  logic [QW-1:0] push_data, head_data;
  logic [1:0]  q_count;
  queue_ctl_t  q_stat;

  // configuration register transfer
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_STRIDE);
  assign stride_nxt = cfg_wr ? pwdata[7:0] : stride_r;
  assign prdata = (paddr[2] == REG_SAMPLE_STRIDE) ? {24'd0, stride_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RESET;
    end else begin
      stride_r <= stride_nxt;
    end
  end

  assign q_stat.count = q_count;
  assign q_stat.push  = push;

  spc_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (in_left_sample),
    .right_sample (in_right_sample),
    .last_sample  (in_last_sample),
    .sample_stride(stride_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  spc_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head_data(head_data),
    .not_empty(q_valid),
    .count    (q_count)
  );

  spc_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .correlation(out_correlation),
    .silent     (out_silent)
  );

  // checks
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.push |-> (q_count != 2'(QUEUE_DEPTH) || pop))
    else $error("block sums lost at full queue");
  a_stride_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (stride_r == $past(pwdata[7:0])))
    else $error("stride register not written");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_correlation)))
    else $error("result dropped while stalled");

endmodule

// ----- test/tb.sv -----
// testbench for the stereo phase correlation block: directed table, random blocks, long full-scale block
`timescale 1ns / 1ps
module tb;
  import spc_pkg::*;

  localparam int ACC_W = ACC_WIDTH_DEF;
  localparam logic [2:0] ADDR_STRIDE = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_left_sample = '0;
  logic signed [15:0] in_right_sample = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_correlation;
  logic out_silent;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stereo_phase_correlation_top DUT (.*);

  always #6 clk = ~clk;

  // expected result of one block
  typedef struct {
    logic signed [15:0] corr;
    logic silent;
  } meter_result_t;

  // one row of the directed table; use_known selects the typed-in result
  typedef struct {
    logic signed [15:0] l;
    logic signed [15:0] r;
    logic last;
    bit use_known;
    logic signed [15:0] corr;
    logic silent;
  } stim_row_t;

  meter_result_t pending_results[$];
  int errors = 0;
  int blocks_seen = 0;
  int pairs_sent = 0;
  bit no_idle = 1'b0;

  // predictor state
  logic [7:0] stride_reg;
  logic signed [ACC_W-1:0] cross_acc, left_acc, right_acc;
  logic [7:0] phase_cnt;

  function automatic logic signed [ACC_W-1:0] sat_sum(logic signed [ACC_W-1:0] a,
                                                      logic signed [63:0] b);
    logic signed [ACC_W+1:0] s;
    s = (ACC_W+2)'(a + b);
    if (s > $signed({2'b0, 1'b0, {(ACC_W-1){1'b1}}})) return {1'b0, {(ACC_W-1){1'b1}}};
    if (s < -$signed({2'b0, 1'b1, {(ACC_W-1){1'b0}}})) return {1'b1, {(ACC_W-1){1'b0}}};
    return s[ACC_W-1:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // advance predictor by one pair; returns 1 when a result is produced
  function automatic bit meter_step(logic signed [15:0] l, logic signed [15:0] r, logic last,
                                    output meter_result_t res);
    logic [7:0] eff;
    logic [63:0] d, mag, rem, q;
    logic signed [63:0] l64, r64;
    bit neg;
    eff = (stride_reg == '0) ? 8'd1 : stride_reg;
    l64 = 64'(l);
    r64 = 64'(r);
    if (phase_cnt == '0) begin
      cross_acc = sat_sum(cross_acc, l64 * r64);
      left_acc = sat_sum(left_acc, l64 * l64);
      right_acc = sat_sum(right_acc, r64 * r64);
    end
    phase_cnt = phase_cnt + 8'd1;
    if (phase_cnt >= eff) phase_cnt = '0;
    if (!last) return 1'b0;
    res.corr = '0;
    res.silent = 1'b0;
    if (left_acc <= 0 || right_acc <= 0) begin
      res.silent = 1'b1;
    end else begin
      d = int_sqrt(64'(left_acc)) * int_sqrt(64'(right_acc));
      neg = cross_acc < 0;
      mag = neg ? 64'(-64'(cross_acc)) : 64'(cross_acc);
      if (mag >= d) begin
        res.corr = neg ? CORR_NEG_MAX : CORR_POS_MAX;
      end else begin
        rem = mag;
        q = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
          rem <<= 1;
          q <<= 1;
          if (rem >= d) begin
            rem -= d;
            q |= 64'd1;
          end
        end
        res.corr = neg ? -16'(q) : 16'(q);
      end
    end
    cross_acc = '0;
    left_acc = '0;
    right_acc = '0;
    phase_cnt = '0;
    return 1'b1;
  endfunction

  // register write: setup cycle then access cycle
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_STRIDE) stride_reg = data[7:0];
  endtask

  // stop sending, wait for all results, then the back end latency
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // send one pair; expectation queued at the transfer
  task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r, logic last,
                           bit use_known, meter_result_t known);
    meter_result_t res;
    bit idle;
    idle = !no_idle && ($urandom_range(99) < 38);
    if (idle) begin
      in_valid <= 1'b0;
      while (idle) begin
        @(posedge clk);
        idle = !no_idle && ($urandom_range(99) < 38);
      end
    end
    in_valid <= 1'b1;
    in_left_sample <= l;
    in_right_sample <= r;
    in_last_sample <= last;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
    if (meter_step(l, r, last, res))
      pending_results.insert(pending_results.size(), use_known ? known : res);
  endtask

  // result side: random stalls, compare each transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer corr=%0d silent=%0b", out_correlation, out_silent);
          errors++;
        end else begin
          meter_result_t e;
          e = pending_results.pop_front();
          if (out_correlation !== e.corr) begin
            $error("correlation expected %0d actual %0d", e.corr, out_correlation);
            errors++;
          end
          if (out_silent !== e.silent) begin
            $error("silent expected %0b actual %0b", e.silent, out_silent);
            errors++;
          end
          blocks_seen++;
        end
      end
      out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #50ms;
    $display("stereo_phase_correlation_top test failed");
    $finish;
  end

  initial begin
    stim_row_t tbl[$];
    meter_result_t known, dummy;
    int len;
    logic signed [15:0] l, r;
    logic [7:0] strides[5];

    strides = '{8'd0, 8'd2, 8'd255, 8'd7, 8'd1};
    stride_reg = STRIDE_RESET;
    cross_acc = '0;
    left_acc = '0;
    right_acc = '0;
    phase_cnt = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: silence, full scale both signs, extremes
    tbl.insert(tbl.size(), stim_row_t'{16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 1'b1});
    tbl.insert(tbl.size(), stim_row_t'{16'sd1000, 16'sd0, 1'b1, 1'b1, 16'sd0, 1'b1});
    tbl.insert(tbl.size(), stim_row_t'{16'sd0, -16'sd5, 1'b1, 1'b1, 16'sd0, 1'b1});
    tbl.insert(tbl.size(), stim_row_t'{16'sd32767, 16'sd32767, 1'b1, 1'b1, 16'sh7fff, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{-16'sd32768, -16'sd32768, 1'b1, 1'b1, 16'sh7fff, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{-16'sd32768, 16'sd32767, 1'b1, 1'b1, -16'sd32768, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{16'sd1, -16'sd1, 1'b1, 1'b1, -16'sd32768, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{16'sd300, 16'sd100, 1'b0, 1'b0, 16'sd0, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{-16'sd200, 16'sd400, 1'b0, 1'b0, 16'sd0, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{16'sd32767, -16'sd32768, 1'b0, 1'b0, 16'sd0, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{16'sd7, 16'sd9000, 1'b1, 1'b0, 16'sd0, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{16'sh5555, 16'shaaaa, 1'b0, 1'b0, 16'sd0, 1'b0});
    tbl.insert(tbl.size(), stim_row_t'{16'shaaaa, 16'sh5555, 1'b1, 1'b0, 16'sd0, 1'b0});
    foreach (tbl[i]) begin
      known.corr = tbl[i].corr;
      known.silent = tbl[i].silent;
      send_pair(tbl[i].l, tbl[i].r, tbl[i].last, tbl[i].use_known, known);
    end

    // sender holds off until every result is in
    drain();
    // unused register index is ignored
    reg_write(ADDR_UNUSED, 32'd9);

    // random blocks across stride settings, one quiet stretch
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(ADDR_STRIDE, {24'($urandom), strides[ph]});
      no_idle = (ph == 3);
      for (int b = 0; b < 44 && pairs_sent < 1740; b++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(5))
            0: begin l = 16'sh7fff; r = -16'sh8000; end
            1: begin l = 16'($urandom); r = l; end
            2: begin l = 16'($urandom); r = -l; end
            3: begin l = '0; r = 16'($urandom); end
            default: begin l = 16'($urandom); r = 16'($urandom); end
          endcase
          send_pair(l, r, k == len - 1, 1'b0, dummy);
        end
      end
      drain();
    end

    // long block at full scale; sums stay well below the accumulator limit
    reg_write(ADDR_STRIDE, 32'd1);
    for (int k = 0; k < 200; k++) send_pair(-16'sh8000, -16'sh8000, k == 199, 1'b0, dummy);
    drain();

    $display("covered %0d pairs and %0d blocks over strides 0, 1, 2, 7, 255", pairs_sent,
             blocks_seen);
    $display("including silent, full-scale and saturated blocks");
    if (errors == 0) begin
      $display("stereo_phase_correlation_top test passed");
    end else begin
      $display("stereo_phase_correlation_top test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/spc_pkg.sv
hw/rtl/spc_fifo.sv
hw/rtl/spc_front.sv
hw/rtl/spc_back.sv
hw/rtl/stereo_phase_correlation_top.sv
test/tb.sv
